// ----- design/websocket_frame_unmask_unit_macros.svh -----
// Assertion macros shared by the websocket frame unmask design.
// Included by every module that carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef WEBSOCKET_FRAME_UNMASK_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_UNMASK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define WFU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wfu assertion failed");
// Check that a condition never becomes true outside reset.
`define WFU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("wfu forbidden condition seen");
`else
`define WFU_ASSERT(lbl, prop)
`define WFU_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- design/wfu_pkg.sv -----
// Package for the websocket frame unmask unit: header constants, phase and result types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package wfu_pkg;

  localparam int unsigned MaxPayloadWidth = 21;
  localparam logic [MaxPayloadWidth-1:0] MaxPayloadReset = 21'd4096;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] FirstByte    = 8'h81;
  localparam logic [7:0] LenMask      = 8'h7F;
  localparam logic [6:0] LenDirectMax = 7'd125;
  localparam logic [6:0] LenExt16     = 7'd126;
  localparam logic [3:0] Ext16Bytes   = 4'd2;
  localparam logic [3:0] Ext64Bytes   = 4'd8;

  typedef enum logic [2:0] {
    PhFirst,
    PhLength,
    PhExtLen,
    PhMask,
    PhPayload
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEmpty   = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic {
    ErrFirstByte = 1'b0,
    ErrTooLong   = 1'b1
  } err_e;

  // One classified result on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] mask;
    kind_e      kind;
    logic       last;
    err_e       code;
  } res_t;

  // Full length against the limit: spilled high bits always exceed it.
  function automatic logic len_exceeds(input logic                       spill,
                                       input logic [MaxPayloadWidth-1:0] len,
                                       input logic [MaxPayloadWidth-1:0] limit);
    len_exceeds = spill | (len > limit);
  endfunction

endpackage

// ----- design/wfu_parser.sv -----
// Front end: accepts stream words, walks the frame header and classifies each word.
// Depends on wfu_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "websocket_frame_unmask_unit_macros.svh"
module wfu_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wfu_pkg::MaxPayloadWidth-1:0] max_payload_i,
  input  logic                                accept_i,
  input  logic [7:0]                          byte_i,
  input  logic                                resync_i,
  output logic                                res_valid_o,
  output wfu_pkg::res_t                       res_o
);
  import wfu_pkg::*;

  phase_e                     phase_q, phase_d;
  logic                       error_q, error_d;
  logic [MaxPayloadWidth-1:0] acc_q, acc_d;
  logic                       spill_q, spill_d;
  logic [3:0]                 left_q, left_d;
  logic [MaxPayloadWidth-1:0] rem_q, rem_d;
  logic [31:0]                mask_q, mask_d;
  logic [1:0]                 pos_q, pos_d;

  logic                       work;
  phase_e                     eff_phase;
  logic [6:0]                 len_code;
  logic [MaxPayloadWidth-1:0] direct_len;
  logic                       direct_over;
  logic [MaxPayloadWidth-1:0] acc_shift;
  logic                       spill_shift;
  logic                       ext_over;
  logic [7:0]                 mask_sel;

  // Resync restarts the frame on this very word; a held error drops the word.
  assign work        = accept_i & (resync_i | ~error_q);
  assign eff_phase   = resync_i ? PhFirst : phase_q;
  assign len_code    = byte_i[6:0] & LenMask[6:0];
  assign direct_len  = {{(MaxPayloadWidth-7){1'b0}}, len_code};
  assign direct_over = len_exceeds(1'b0, direct_len, max_payload_i);
  assign acc_shift   = {acc_q[MaxPayloadWidth-9:0], byte_i};
  assign spill_shift = spill_q | (|acc_q[MaxPayloadWidth-1:MaxPayloadWidth-8]);
  assign ext_over    = len_exceeds(spill_shift, acc_shift, max_payload_i);
  // First mask byte sits in the top byte of the key.
  assign mask_sel    = mask_q[{~pos_q, 3'b000} +: 8];

  // Next state
  always_comb begin
    phase_d = phase_q;
    error_d = error_q;
    acc_d   = acc_q;
    spill_d = spill_q;
    left_d  = left_q;
    rem_d   = rem_q;
    mask_d  = mask_q;
    pos_d   = pos_q;
    if (work) begin
      if (resync_i) begin
        error_d = 1'b0;
      end
      unique case (eff_phase)
        PhLength: begin
          if (len_code <= LenDirectMax) begin
            if (direct_over) begin
              error_d = 1'b1;
              phase_d = PhFirst;
            end else begin
              rem_d   = direct_len;
              pos_d   = 2'd0;
              phase_d = PhMask;
            end
          end else begin
            acc_d   = '0;
            spill_d = 1'b0;
            left_d  = (len_code == LenExt16) ? Ext16Bytes : Ext64Bytes;
            phase_d = PhExtLen;
          end
        end
        PhExtLen: begin
          acc_d   = acc_shift;
          spill_d = spill_shift;
          left_d  = left_q - 4'd1;
          if (left_q == 4'd1) begin
            if (ext_over) begin
              error_d = 1'b1;
              phase_d = PhFirst;
            end else begin
              rem_d   = acc_shift;
              pos_d   = 2'd0;
              phase_d = PhMask;
            end
          end
        end
        PhMask: begin
          mask_d = {mask_q[23:0], byte_i};
          pos_d  = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            phase_d = (rem_q == '0) ? PhFirst : PhPayload;
          end
        end
        PhPayload: begin
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - {{(MaxPayloadWidth-1){1'b0}}, 1'b1};
          if (rem_q == {{(MaxPayloadWidth-1){1'b0}}, 1'b1}) begin
            phase_d = PhFirst;
          end
        end
        default: begin
          if (byte_i != FirstByte) begin
            error_d = 1'b1;
            phase_d = PhFirst;
          end else begin
            phase_d = PhLength;
          end
        end
      endcase
    end
  end

  // Result classification
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '{raw: 8'h00, mask: 8'h00, kind: KindPayload, last: 1'b0,
                    code: ErrFirstByte};
    if (work) begin
      unique case (eff_phase)
        PhLength: begin
          if ((len_code <= LenDirectMax) && direct_over) begin
            res_valid_o = 1'b1;
            res_o.kind  = KindError;
            res_o.code  = ErrTooLong;
          end
        end
        PhExtLen: begin
          if ((left_q == 4'd1) && ext_over) begin
            res_valid_o = 1'b1;
            res_o.kind  = KindError;
            res_o.code  = ErrTooLong;
          end
        end
        PhMask: begin
          if ((pos_q == 2'd3) && (rem_q == '0)) begin
            res_valid_o = 1'b1;
            res_o.kind  = KindEmpty;
            res_o.last  = 1'b1;
          end
        end
        PhPayload: begin
          res_valid_o = 1'b1;
          res_o.raw   = byte_i;
          res_o.mask  = mask_sel;
          res_o.last  = (rem_q == {{(MaxPayloadWidth-1){1'b0}}, 1'b1});
        end
        default: begin
          if (byte_i != FirstByte) begin
            res_valid_o = 1'b1;
            res_o.kind  = KindError;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      error_q <= 1'b0;
      acc_q   <= '0;
      spill_q <= 1'b0;
      left_q  <= '0;
      rem_q   <= '0;
      mask_q  <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      error_q <= error_d;
      acc_q   <= acc_d;
      spill_q <= spill_d;
      left_q  <= left_d;
      rem_q   <= rem_d;
      mask_q  <= mask_d;
      pos_q   <= pos_d;
    end
  end

  `WFU_ASSERT(a_payload_has_bytes, (phase_q == PhPayload) |-> (rem_q != '0))
  `WFU_ASSERT(a_error_parks_header, error_q |-> (phase_q == PhFirst))
  `WFU_ASSERT(a_payload_aligned, (phase_q == PhMask && phase_d == PhPayload) |-> (pos_d == 2'd0))

endmodule

// ----- design/wfu_queue.sv -----
// Short result queue between the parser and the output stage.
// Depends on wfu_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "websocket_frame_unmask_unit_macros.svh"
module wfu_queue #(
  parameter int unsigned DEPTH = wfu_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wfu_pkg::res_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          not_empty_o,
  output wfu_pkg::res_t pop_data_o
);
  import wfu_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  res_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == FullCnt);
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrOne;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrOne;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntOne;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `WFU_ASSERT(a_count_in_range, cnt_q <= FullCnt)
  `WFU_ASSERT_NEVER(a_push_into_full, push_i && full_o)
  `WFU_ASSERT_NEVER(a_pop_from_empty, pop_i && !not_empty_o)

endmodule

// ----- design/wfu_out_stage.sv -----
// Back end: pulls classified results, applies the mask and drives the output register.
// Depends on wfu_pkg.
`timescale 1ns / 1ps
module wfu_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  wfu_pkg::res_t res_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [7:0]    byte_o,
  output logic [2:0]    user_o,
  output logic          last_o
);
  import wfu_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;
  err_e       code_q;

  // Refill the register when it is empty or its word leaves this cycle.
  assign pop_o   = avail_i & (~valid_q | ready_i);
  assign valid_d = pop_o | (valid_q & ~ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= res_i.raw ^ res_i.mask;
      kind_q <= res_i.kind;
      last_q <= res_i.last;
      code_q <= res_i.code;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign user_o  = {code_q, kind_q};
  assign last_o  = last_q;

endmodule

// ----- design/websocket_frame_unmask_unit.sv -----
// Top level of the websocket frame unmask unit.
// Depends on wfu_pkg, wfu_parser, wfu_queue and wfu_out_stage.
`timescale 1ns / 1ps
// Receives a client WebSocket byte stream, one byte per word, and returns the
// unmasked payload. Each frame must open with 0x81; the length byte follows
// (126: 16-bit big-endian extended length, 127: 64-bit), then four mask bytes,
// then the payload, whose bytes are XORed with the mask in turn and sent out
// with tlast on the final one. A frame with no payload yields one "empty frame"
// word with tlast set. A bad first byte or a length above max_payload yields an
// error word and the unit then drops every byte until a word arrives with the
// resync flag, which also abandons any frame in progress and counts as a first
// byte. The unit takes one byte every clock cycle while the result queue has room:
// the header walk and the mask select keep pace with the input, and the result
// queue plus the output register let the input keep running while the output
// stalls until the queue fills. A result is written into the queue as its byte
// is taken and from there moves into the output register once that is free. No
// clearing pass is needed after reset. Write max_payload only while idle.
module websocket_frame_unmask_unit #(
  parameter int unsigned QUEUE_DEPTH = wfu_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wfu_pkg::MaxPayloadWidth-1:0] cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] resync
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                          m_axis_tuser,  // [1:0] out_kind, [2] error_code
  output logic                                m_axis_tlast   // last_of_frame
);
  import wfu_pkg::*;

  logic [MaxPayloadWidth-1:0] max_payload_q;
  logic                       in_accept;
  logic                       res_valid;
  res_t                       res;
  logic                       q_full;
  logic                       q_avail;
  logic                       q_pop;
  res_t                       q_data;

  // Hold the payload limit; the user must write it only while the unit is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Take a byte whenever the queue has room for a possible result.
  assign s_axis_tready = ~q_full;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  wfu_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_payload_i (max_payload_q),
    .accept_i      (in_accept),
    .byte_i        (s_axis_tdata),
    .resync_i      (s_axis_tuser),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  wfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_avail),
    .pop_data_o  (q_data)
  );

  wfu_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .res_i   (q_data),
    .pop_o   (q_pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .user_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/sv/wfu_stream_compare.sv -----
// Stream monitor for the websocket frame unmask unit: decodes accepted input bytes itself
// and compares each accepted output word, in order, field by field. Depends on wfu_pkg.
`timescale 1ns / 1ps
module wfu_stream_compare
  import wfu_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [MaxPayloadWidth-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,
  input  logic                       s_axis_tuser,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [7:0]                 m_axis_tdata,
  input  logic [2:0]                 m_axis_tuser,
  input  logic                       m_axis_tlast,
  output int unsigned                mismatch_count_o,
  output int unsigned                words_due_o,
  output int unsigned                payload_words_o,
  output int unsigned                empty_words_o,
  output int unsigned                error_words_o
);

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
    err_e       code;
  } out_word_t;

  logic [MaxPayloadWidth-1:0] limit_q;
  phase_e                     phase_q;
  logic [63:0]                len_acc_q;
  logic [3:0]                 ext_left_q;
  logic [63:0]                remain_q;
  logic [31:0]                key_q;
  logic [1:0]                 key_pos_q;
  logic                       hold_q;

  out_word_t   words_due[$];
  out_word_t   fresh;
  out_word_t   want;
  int unsigned fail_total;
  int unsigned n_payload;
  int unsigned n_empty;
  int unsigned n_error;

  function automatic void drop_frame();
    phase_q    = PhFirst;
    len_acc_q  = '0;
    ext_left_q = '0;
    remain_q   = '0;
    key_q      = '0;
    key_pos_q  = '0;
  endfunction

  function automatic out_word_t error_word(input err_e code);
    out_word_t w;
    drop_frame();
    hold_q = 1'b1;
    w      = '0;
    w.kind = KindError;
    w.code = code;
    return w;
  endfunction

  // Length is complete: reject it at once or move on to the key bytes.
  function automatic bit close_length(output out_word_t w);
    w = '0;
    if (len_acc_q > 64'(limit_q)) begin
      w = error_word(ErrTooLong);
      return 1'b1;
    end
    remain_q  = len_acc_q;
    key_q     = '0;
    key_pos_q = '0;
    phase_q   = PhMask;
    return 1'b0;
  endfunction

  // Advance the frame walk by one byte; returns 1 when the byte yields a word.
  function automatic bit decode_byte(input logic [7:0] b, input logic rs, output out_word_t w);
    logic [6:0] code;
    logic [7:0] key_byte;
    w = '0;
    if (rs) begin
      hold_q = 1'b0;
      drop_frame();
    end else if (hold_q) begin
      return 1'b0;
    end
    case (phase_q)
      PhLength: begin
        code      = 7'(b & LenMask);
        len_acc_q = (code <= LenDirectMax) ? 64'(code) : '0;
        if (code <= LenDirectMax) return close_length(w);
        ext_left_q = (code == LenExt16) ? Ext16Bytes : Ext64Bytes;
        phase_q    = PhExtLen;
        return 1'b0;
      end
      PhExtLen: begin
        len_acc_q  = {len_acc_q[55:0], b};
        ext_left_q = ext_left_q - 4'd1;
        if (ext_left_q == 4'd0) return close_length(w);
        return 1'b0;
      end
      PhMask: begin
        key_q     = {key_q[23:0], b};
        key_pos_q = key_pos_q + 2'd1;
        if (key_pos_q != 2'd0) return 1'b0;
        if (remain_q == 64'd0) begin
          drop_frame();
          w.kind = KindEmpty;
          w.last = 1'b1;
          return 1'b1;
        end
        phase_q = PhPayload;
        return 1'b0;
      end
      PhPayload: begin
        key_byte  = key_q[8*(3 - int'(key_pos_q)) +: 8];
        key_pos_q = key_pos_q + 2'd1;
        remain_q  = remain_q - 64'd1;
        w.data    = b ^ key_byte;
        w.kind    = KindPayload;
        w.last    = (remain_q == 64'd0);
        if (w.last) drop_frame();
        return 1'b1;
      end
      default: begin
        if (b != FirstByte) begin
          w = error_word(ErrFirstByte);
          return 1'b1;
        end
        drop_frame();
        phase_q = PhLength;
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    = MaxPayloadReset;
      hold_q     = 1'b0;
      drop_frame();
      words_due.delete();
      fail_total = 0;
      n_payload  = 0;
      n_empty    = 0;
      n_error    = 0;
    end else begin
      // Outputs first: a word leaving now always stems from an older byte.
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          $error("output word with none due: out_byte %h out_kind %0d last %b code %b",
                 m_axis_tdata, m_axis_tuser[1:0], m_axis_tlast, m_axis_tuser[2]);
          fail_total++;
        end else begin
          want = words_due.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, m_axis_tdata);
            fail_total++;
          end
          if (m_axis_tuser[1:0] !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, m_axis_tuser[1:0]);
            fail_total++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_frame: expected %b, actual %b", want.last, m_axis_tlast);
            fail_total++;
          end
          if (m_axis_tuser[2] !== want.code) begin
            $error("error_code: expected %b, actual %b", want.code, m_axis_tuser[2]);
            fail_total++;
          end
          case (want.kind)
            KindPayload: n_payload++;
            KindEmpty:   n_empty++;
            default:     n_error++;
          endcase
        end
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready && decode_byte(s_axis_tdata, s_axis_tuser, fresh))
        words_due.push_back(fresh);
    end
    mismatch_count_o <= fail_total;
    words_due_o      <= words_due.size();
    payload_words_o  <= n_payload;
    empty_words_o    <= n_empty;
    error_words_o    <= n_error;
  end

endmodule

// ----- tb/sv/websocket_frame_unmask_unit_test.sv -----
// Top of the websocket frame unmask unit regression: clock, reset, byte stimulus and verdict.
// Depends on wfu_pkg, websocket_frame_unmask_unit and the wfu_stream_compare monitor.
`timescale 1ns / 1ps
module websocket_frame_unmask_unit_test;
  import wfu_pkg::*;

  // Long receiver hold-off, the quiet tail after draining, and the run watchdog.
  // A run is some 500 to 800 words plus one hold-off: far below the limit.
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned CycleLimit     = 200000;
  // Payloads longer than this are cut short and abandoned by a resync.
  localparam int unsigned LongestPayload = 64;
  localparam logic [6:0]  LenExt64       = 7'd127;
  localparam int unsigned KeepAll        = 32'hFFFF_FFFF;

  // How a frame carries its length.
  typedef enum int unsigned {
    LenDirect,
    LenShort,
    LenLong
  } len_form_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [MaxPayloadWidth-1:0] cfg_wdata_i;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata;
  logic                       s_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [7:0]                 m_axis_tdata;
  logic [2:0]                 m_axis_tuser;
  logic                       m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned words_due;
  int unsigned payload_words;
  int unsigned empty_words;
  int unsigned error_words;

  int unsigned                tx_idle_pct;
  int unsigned                rx_stall_pct;
  bit                         hold_req;
  bit                         need_resync;
  logic [MaxPayloadWidth-1:0] cur_limit;
  int unsigned                words_sent;
  int unsigned                cycle_count;

  websocket_frame_unmask_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The monitor predicts and compares; this module only drives and judges.
  wfu_stream_compare u_compare (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due),
    .payload_words_o  (payload_words),
    .empty_words_o    (empty_words),
    .error_words_o    (error_words)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("websocket_frame_unmask_unit regression: fail");
      $finish;
    end
  end

  // Receiver: stall at the phase's rate; once per request, hold off for a long stretch
  // so the result queue fills and the unit pushes back on its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_word(input logic [7:0] b, input logic rs);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // Update max_payload; call only with nothing in flight.
  task automatic write_limit(input logic [MaxPayloadWidth-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit    = value;
  endtask

  // Wait until every due word has come out, then let the pipeline run empty.
  task automatic settle();
    do @(posedge clk_i); while (words_due != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Build one frame (header, key, payload) and offer its first `keep` bytes.
  // An oversized length ends the frame after the header: the unit drops the rest anyway.
  // Anything that leaves the unit in error or mid-frame makes the next frame lead with resync.
  task automatic send_frame(input logic [63:0] len, input int unsigned keep);
    logic [7:0] frame_bytes[$];
    len_form_e  form;
    logic       lead_rs;
    lead_rs     = need_resync | ($urandom_range(9, 0) == 0);
    need_resync = 1'b0;
    if (len <= LenDirectMax) form = len_form_e'($urandom_range(2, 0));
    else if (len <= 64'hFFFF) form = len_form_e'($urandom_range(2, 1));
    else form = LenLong;
    frame_bytes.push_back(FirstByte);
    // The mask bit of the length byte is random: the unit must ignore it.
    case (form)
      LenDirect: frame_bytes.push_back({1'($urandom), len[6:0]});
      LenShort: begin
        frame_bytes.push_back({1'($urandom), LenExt16});
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
      end
      default: begin
        frame_bytes.push_back({1'($urandom), LenExt64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8*i +: 8]);
      end
    endcase
    if (len > 64'(cur_limit)) begin
      need_resync = 1'b1;
    end else begin
      repeat (4) frame_bytes.push_back(8'($urandom));
      if (len > LongestPayload) begin
        repeat ($urandom_range(30, 1)) frame_bytes.push_back(8'($urandom));
        need_resync = 1'b1;
      end else begin
        repeat (int'(len)) frame_bytes.push_back(8'($urandom));
      end
    end
    if (keep < frame_bytes.size()) need_resync = 1'b1;
    foreach (frame_bytes[i])
      if (i < keep) send_word(frame_bytes[i], (i == 0) ? lead_rs : 1'b0);
  endtask

  // One random phase under one max_payload setting and one idling pattern.
  // Mostly well-formed frames (short, near the limit, huge, cut short), the rest noise.
  task automatic run_phase(input logic [MaxPayloadWidth-1:0] limit, input int unsigned idle_pct,
                           input int unsigned stall_pct, input bit long_hold,
                           input int unsigned words);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned shape;
    int unsigned keep;
    logic [63:0] len;
    write_limit(limit);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    hold_req     = long_hold;
    need_resync  = 1'b1;
    stop_at      = words_sent + words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        shape = $urandom_range(99, 0);
        if (shape < 65) len = 64'($urandom_range(24, 0));
        else if (shape < 75) len = 64'($urandom_range(LongestPayload, 25));
        else if (shape < 88) len = 64'(cur_limit) + 64'($urandom_range(1, 0));
        else len = {$urandom, $urandom};
        keep = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 1) : KeepAll;
        send_frame(len, keep);
      end else if (pick < 92) begin
        // stray bytes where a frame should start
        repeat ($urandom_range(3, 1)) send_word(8'($urandom), 1'b0);
        need_resync = 1'b1;
      end else begin
        send_word(8'($urandom), 1'($urandom));
        need_resync = 1'b1;
      end
    end
    s_axis_tvalid <= 1'b0;
    settle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_req      = 1'b0;
    need_resync   = 1'b0;
    cur_limit     = MaxPayloadReset;
    words_sent    = 0;
    cycle_count   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad first byte, a byte swallowed by the error hold, resync into an empty
    // frame, a short payload, a 64-bit length with its top bit set, resync on a bad byte.
    send_word(8'h00, 1'b0);
    send_word(FirstByte, 1'b0);
    send_word(FirstByte, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b0);
    send_word(8'h56, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(FirstByte, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(FirstByte, 1'b0);
    send_word({1'b1, LenExt64}, 1'b0);
    send_word(8'h80, 1'b0);
    repeat (7) send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    s_axis_tvalid <= 1'b0;
    settle();

    // Random: limit of zero, a small limit, the largest limit (with the long hold-off),
    // the reset value again, and a mid value; the first and last with no idling, the rest each with its own pattern.
    run_phase(21'd0,        0,  0,  1'b0, 90);
    run_phase(21'd12,       60, 0,  1'b0, 90);
    run_phase(21'h1F_FFFF,  0,  60, 1'b1, 90);
    run_phase(MaxPayloadReset, 30, 30, 1'b0, 90);
    run_phase(21'd300,      0,  0,  1'b0, 90);

    $display("Drove %0d input bytes through limits 0, 12, 300, 4096 and 2^21-1 under idle, stall",
             words_sent);
    $display("and hold-off phases; checked %0d payload, %0d empty-frame and %0d error words.",
             payload_words, empty_words, error_words);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("websocket_frame_unmask_unit regression: pass");
    end else begin
      $display("websocket_frame_unmask_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/wfu_pkg.sv
design/wfu_parser.sv
design/wfu_queue.sv
design/wfu_out_stage.sv
design/websocket_frame_unmask_unit.sv
tb/sv/wfu_stream_compare.sv
tb/sv/websocket_frame_unmask_unit_test.sv
